@@ rtl/trfd_pkg.sv @@
`default_nettype none

package trfd_pkg;

  // Item kinds carried in tuser
  typedef enum logic [1:0] {
    KIND_BYTE      = 2'd0,
    KIND_TICK      = 2'd1,
    KIND_CLR_FRONT = 2'd2,
    KIND_CLR_REAR  = 2'd3
  } kind_e;

  // Channel named by the second message byte
  typedef enum logic [1:0] {
    CH_NONE  = 2'd0,
    CH_FRONT = 2'd1,
    CH_REAR  = 2'd2
  } chan_e;

  // Percent-escape progress
  typedef enum logic [1:0] {
    ESC_IDLE = 2'd0,
    ESC_HI   = 2'd1,
    ESC_LO   = 2'd2
  } esc_e;

  // Configuration register indexes
  localparam logic [1:0] CFG_TIMEOUT_LIMIT  = 2'd0;
  localparam logic [1:0] CFG_ID_UPPER_BOUND = 2'd1;
  localparam logic [1:0] CFG_PAYLOAD_START  = 2'd2;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Register reset values
  localparam logic [7:0]  TIMEOUT_LIMIT_RST  = 8'd20;
  localparam logic [15:0] ID_UPPER_BOUND_RST = 16'd1200;
  localparam logic [7:0]  PAYLOAD_START_RST  = 8'd27;

  localparam int unsigned MAX_MSG_BYTES_DEF = 512;

  // Message characters
  localparam logic [7:0] ESC_CHAR = 8'h25; // '%'
  localparam logic [7:0] CHAR_F   = 8'h46;
  localparam logic [7:0] CHAR_R   = 8'h52;

  // First payload byte index, and byte index from which a message is long enough
  // to carry a tag ID (length above 25)
  localparam int unsigned FIRST_PAYLOAD_POS = 2;
  localparam int unsigned ID_MIN_LAST_POS   = 25;

  localparam int unsigned CAPTURE_DEPTH = 7;
  localparam int unsigned CAP_IDX_W     = 3;

  localparam int unsigned OUT_DATA_W = 48;

  // Result of a finished message, handed from the byte decoder to the status logic
  typedef struct packed {
    logic        fire;
    logic        rear;
    logic        tag_ok;
    logic [15:0] tag_id;
    logic [7:0]  tick;
  } finish_t;

  // Hex digit: bit 4 set when the byte is a digit, low bits its value
  function automatic logic [4:0] hex_digit(logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/tag_reader_frame_decoder.sv @@
`default_nettype none

// Tag-reader frame decoder. Each slave word is one item, its kind in tuser: a message
// byte (tlast on the final byte), a timer tick, or a clear of the front or rear detect
// bit. Messages are a tick byte, a channel letter F or R, then payload that is
// percent-decoded from byte payload_start on; the tag ID is checked and latched when the
// message ends. Only a timer tick produces a master word, carrying the status of both
// channels; it sits in an output register in the cycle after the tick is taken. One item
// is taken every cycle while the output register is empty or being drained, since each
// item is handled by one pass of shallow logic into the state and result registers.
// Configuration writes take effect on the next edge and are meant for idle periods.
module tag_reader_frame_decoder import trfd_pkg::*; #(
  parameter int unsigned MAX_MESSAGE_BYTES = MAX_MSG_BYTES_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // config write port
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  // slave side
  input  wire logic                  s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  wire logic [7:0]            s_axis_tdata_i,  // [7:0] data_byte
  input  wire logic                  s_axis_tlast_i,  // last_byte
  input  wire logic [1:0]            s_axis_tuser_i,  // [1:0] kind
  // master side
  output logic                       m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  // [3:0] front_flags, [7:4] rear_flags, [23:8] front_tag_id, [39:24] rear_tag_id,
  // [40] front_connected, [41] rear_connected, [47:42] zero
  output logic [OUT_DATA_W-1:0]      m_axis_tdata_o
);

  logic [7:0]  timeout_limit_q;
  logic [15:0] id_upper_bound_q;
  logic [7:0]  payload_start_q;

  logic [7:0]  ctick_q [2];
  logic [7:0]  ctick_d [2];
  logic [7:0]  seen_q  [2];
  logic [7:0]  seen_d  [2];
  logic [7:0]  idle_q  [2];
  logic [7:0]  idle_d  [2];
  logic [7:0]  idle_n  [2];
  logic [15:0] id_q    [2];
  logic [15:0] id_d    [2];
  logic [1:0]  det_q, det_d;
  logic [1:0]  tmo_q, tmo_d;
  logic [1:0]  conn_q, conn_d;

  logic                  out_valid_q, out_valid_d;
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;

  logic    in_acc;
  kind_e   kind;
  finish_t fin;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign kind            = kind_e'(s_axis_tuser_i);

  trfd_msg #(
    .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
  ) u_msg (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .byte_en_i       (in_acc && kind == KIND_BYTE),
    .data_i          (s_axis_tdata_i),
    .last_i          (s_axis_tlast_i),
    .payload_start_i (payload_start_q),
    .id_upper_bound_i(id_upper_bound_q),
    .fin_o           (fin)
  );

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_limit_q  <= TIMEOUT_LIMIT_RST;
      id_upper_bound_q <= ID_UPPER_BOUND_RST;
      payload_start_q  <= PAYLOAD_START_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TIMEOUT_LIMIT:  timeout_limit_q  <= cfg_data_i[7:0];
        CFG_ID_UPPER_BOUND: id_upper_bound_q <= cfg_data_i[15:0];
        CFG_PAYLOAD_START:  payload_start_q  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Channel status: message end, tick timeout tracking, detect clears
  always_comb begin
    ctick_d = ctick_q;
    seen_d  = seen_q;
    idle_d  = idle_q;
    id_d    = id_q;
    det_d   = det_q;
    tmo_d   = tmo_q;
    conn_d  = conn_q;
    for (int c = 0; c < 2; c++) begin
      if (seen_q[c] == ctick_q[c]) begin
        idle_n[c] = (idle_q[c] == 8'hFF) ? idle_q[c] : idle_q[c] + 8'd1;
      end else begin
        idle_n[c] = 8'd0;
      end
    end
    if (in_acc) begin
      unique case (kind)
        KIND_BYTE: begin
          for (int c = 0; c < 2; c++) begin
            if (fin.fire && fin.rear == 1'(c)) begin
              ctick_d[c] = fin.tick;
              conn_d[c]  = 1'b1;
              if (fin.tag_ok) begin
                det_d[c] = 1'b1;
                id_d[c]  = fin.tag_id;
              end
            end
          end
        end
        KIND_TICK: begin
          for (int c = 0; c < 2; c++) begin
            seen_d[c] = ctick_q[c];
            if (idle_n[c] >= timeout_limit_q) begin
              idle_d[c] = timeout_limit_q;
              tmo_d[c]  = 1'b1;
              conn_d[c] = 1'b0;
            end else begin
              idle_d[c] = idle_n[c];
              tmo_d[c]  = 1'b0;
            end
          end
        end
        KIND_CLR_FRONT: det_d[0] = 1'b0;
        KIND_CLR_REAR:  det_d[1] = 1'b0;
        default: ;
      endcase
    end
  end

  // Output register: loaded on a tick, drained by the master side
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (in_acc && kind == KIND_TICK) begin
      out_valid_d = 1'b1;
      out_data_d  = {6'd0, conn_d[1], conn_d[0], id_d[1], id_d[0],
                     1'b0, tmo_d[1], 1'b0, det_d[1],
                     1'b0, tmo_d[0], 1'b0, det_d[0]};
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < 2; c++) begin
        ctick_q[c] <= 8'd0;
        seen_q[c]  <= 8'd0;
        idle_q[c]  <= 8'd0;
        id_q[c]    <= 16'd0;
      end
      det_q       <= 2'd0;
      tmo_q       <= 2'd0;
      conn_q      <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      ctick_q     <= ctick_d;
      seen_q      <= seen_d;
      idle_q      <= idle_d;
      id_q        <= id_d;
      det_q       <= det_d;
      tmo_q       <= tmo_d;
      conn_q      <= conn_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

`default_nettype wire

@@ rtl/trfd_msg.sv @@
`default_nettype none

module trfd_msg import trfd_pkg::*; #(
  parameter int unsigned MAX_MESSAGE_BYTES = MAX_MSG_BYTES_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        byte_en_i,
  input  wire logic [7:0]  data_i,
  input  wire logic        last_i,
  input  wire logic [7:0]  payload_start_i,
  input  wire logic [15:0] id_upper_bound_i,
  output finish_t          fin_o
);

  localparam int unsigned PosW = $clog2(MAX_MESSAGE_BYTES + 1);
  localparam int unsigned CmpW = (PosW > 8) ? PosW : 8;

  logic [PosW-1:0]      pos_q, pos_d;
  chan_e                chan_q, chan_d;
  logic [7:0]           tick_q, tick_d;
  esc_e                 phase_q, phase_d;
  logic [7:0]           acc_q, acc_d;
  logic                 hvalid_q, hvalid_d;
  logic [CAP_IDX_W-1:0] idx_q, idx_d;
  logic                 ended_q, ended_d;
  logic [7:0]           cap_q [CAPTURE_DEPTH];
  logic [7:0]           cap_d [CAPTURE_DEPTH];

  logic       clear;
  logic       store_en;
  logic [7:0] store_val;
  logic [4:0] hv;
  logic [31:0] id;

  assign hv = hex_digit(data_i);

  // Byte step: header, zero terminator, percent decoding, final flush
  always_comb begin
    pos_d     = pos_q;
    chan_d    = chan_q;
    tick_d    = tick_q;
    phase_d   = phase_q;
    acc_d     = acc_q;
    hvalid_d  = hvalid_q;
    ended_d   = ended_q;
    clear     = 1'b0;
    store_en  = 1'b0;
    store_val = acc_q;
    if (byte_en_i) begin
      priority if (pos_q == '0) begin
        tick_d   = data_i;
        chan_d   = CH_NONE;
        phase_d  = ESC_IDLE;
        acc_d    = 8'd0;
        hvalid_d = 1'b0;
        ended_d  = 1'b0;
        clear    = 1'b1;
      end else if (pos_q == PosW'(1)) begin
        chan_d = (data_i == CHAR_F) ? CH_FRONT : (data_i == CHAR_R) ? CH_REAR : CH_NONE;
      end else if (!ended_q && pos_q < PosW'(MAX_MESSAGE_BYTES)) begin
        if (data_i == 8'd0) begin
          // zero byte ends the payload, keeping any partial escape
          if (phase_q != ESC_IDLE) begin
            store_en  = 1'b1;
            store_val = acc_q;
          end
          phase_d = ESC_IDLE;
          ended_d = 1'b1;
        end else if (CmpW'(pos_q) >= CmpW'(payload_start_i)) begin
          if (phase_q == ESC_IDLE) begin
            if (data_i == ESC_CHAR) begin
              phase_d  = ESC_HI;
              acc_d    = 8'd0;
              hvalid_d = 1'b1;
            end else begin
              store_en  = 1'b1;
              store_val = data_i;
            end
          end else begin
            // only leading hex digits count
            if (hvalid_q && hv[4]) begin
              acc_d = {acc_q[3:0], hv[3:0]};
            end else begin
              hvalid_d = 1'b0;
            end
            if (phase_q == ESC_LO) begin
              store_en  = 1'b1;
              store_val = acc_d;
              phase_d   = ESC_IDLE;
            end else begin
              phase_d = ESC_LO;
            end
          end
        end
      end else begin
        // payload already ended or message past the length cap: nothing decoded
      end
      if (last_i) begin
        // escape cut short by the end of the message
        if (phase_d != ESC_IDLE) begin
          store_en  = 1'b1;
          store_val = acc_d;
          phase_d   = ESC_IDLE;
        end
        pos_d = '0;
      end else if (pos_q < PosW'(MAX_MESSAGE_BYTES)) begin
        pos_d = pos_q + PosW'(1);
      end
    end
  end

  // Capture of the first decoded bytes
  always_comb begin
    idx_d = idx_q;
    if (clear) begin
      idx_d = '0;
    end else if (store_en && idx_q < CAP_IDX_W'(CAPTURE_DEPTH)) begin
      idx_d = idx_q + CAP_IDX_W'(1);
    end
    for (int i = 0; i < CAPTURE_DEPTH; i++) begin
      if (clear) begin
        cap_d[i] = 8'd0;
      end else if (store_en && idx_q == CAP_IDX_W'(i)) begin
        cap_d[i] = store_val;
      end else begin
        cap_d[i] = cap_q[i];
      end
    end
  end

  // Tag ID: Open32 layout when the low six bits of byte 1 are all set
  always_comb begin
    id[21:0] = {cap_d[2], cap_d[3], cap_d[4][7:2]};
    if (cap_d[1][5:0] == 6'h3F) begin
      id[31:22] = {cap_d[0], cap_d[1][7:6]};
    end else begin
      id[31:22] = {4'd0, cap_d[1][5:0]};
    end
  end

  always_comb begin
    fin_o.fire   = byte_en_i && last_i && (chan_d == CH_FRONT || chan_d == CH_REAR);
    fin_o.rear   = (chan_d == CH_REAR);
    fin_o.tag_ok = (pos_q >= PosW'(ID_MIN_LAST_POS)) && (id[31:16] == 16'd0) &&
                   (id[15:0] != 16'd0) && (id[15:0] < id_upper_bound_i);
    fin_o.tag_id = id[15:0];
    fin_o.tick   = tick_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      chan_q   <= CH_NONE;
      tick_q   <= 8'd0;
      phase_q  <= ESC_IDLE;
      acc_q    <= 8'd0;
      hvalid_q <= 1'b0;
      idx_q    <= '0;
      ended_q  <= 1'b0;
      for (int i = 0; i < CAPTURE_DEPTH; i++) begin
        cap_q[i] <= 8'd0;
      end
    end else begin
      pos_q    <= pos_d;
      chan_q   <= chan_d;
      tick_q   <= tick_d;
      phase_q  <= phase_d;
      acc_q    <= acc_d;
      hvalid_q <= hvalid_d;
      idx_q    <= idx_d;
      ended_q  <= ended_d;
      for (int i = 0; i < CAPTURE_DEPTH; i++) begin
        cap_q[i] <= cap_d[i];
      end
    end
  end

endmodule

`default_nettype wire
